[src/acr_pkg.sv]
// Shared types and constants for the rectangle collision response pipeline.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package acr_pkg;

	// Default coordinate width: signed centers and velocities, sizes one bit narrower
	localparam int COORD_BITS_DEF = 24;

	localparam logic [7:0] REST_LIMIT_RESET = 8'd3;

	// Push direction codes, 2-bit two's complement
	localparam logic signed [1:0] NORM_ZERO = 2'sb00;
	localparam logic signed [1:0] NORM_POS  = 2'sb01;
	localparam logic signed [1:0] NORM_NEG  = 2'sb11;

	// Per-axis status handed from the span stages to the decision stages
	typedef struct packed {
		logic overlap;   // spans overlap on this axis
		logic neg;       // entry normal is -1 (else +1)
		logic usable;    // velocity nonzero and along the normal
		logic slow;      // |v| below rest_limit
	} axis_flags_t;

endpackage

[src/acr_axis.sv]
// One axis of the collision test: span bounds (stage 1), overlap, side and
// push-out distance at double scale (stage 2). Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_axis import acr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en_s1,
	input  logic                         en_s2,
	input  logic [7:0]                   rest_limit,
	input  logic signed [COORD_BITS-1:0] c1,
	input  logic        [COORD_BITS-2:0] s1,
	input  logic signed [COORD_BITS-1:0] c2,
	input  logic        [COORD_BITS-2:0] s2,
	input  logic signed [COORD_BITS-1:0] v,
	output axis_flags_t                  flags,
	output logic        [COORD_BITS-1:0] dist2,
	output logic        [COORD_BITS-1:0] mag
);

	localparam int W = COORD_BITS;

	logic signed [W+1:0] lo1_c, hi1_c, lo2_c, hi2_c;
	logic        [W-1:0] vu, mag_c;

	logic signed [W+1:0] lo1_s1, hi1_s1, lo2_s1, hi2_s1;
	logic        [W-1:0] mag_s1;
	logic                vneg_s1, vnz_s1;

	logic signed [W+2:0] da, db;
	logic                lt, ov;
	logic        [W-1:0] dsel;

	axis_flags_t         flags_s2;
	logic        [W-1:0] dist2_s2, mag_s2;

	// Spans at twice the scale so half sizes stay exact
	always_comb begin
		lo1_c = ((W+2)'(c1) <<< 1) - $signed({3'b000, s1});
		hi1_c = ((W+2)'(c1) <<< 1) + $signed({3'b000, s1});
		lo2_c = ((W+2)'(c2) <<< 1) - $signed({3'b000, s2});
		hi2_c = ((W+2)'(c2) <<< 1) + $signed({3'b000, s2});
		vu    = v;
		mag_c = vu[W-1] ? (~vu + W'(1)) : vu;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			lo1_s1  <= lo1_c;
			hi1_s1  <= hi1_c;
			lo2_s1  <= lo2_c;
			hi2_s1  <= hi2_c;
			mag_s1  <= mag_c;
			vneg_s1 <= v[W-1];
			vnz_s1  <= (v != '0);
		end
	end

	// Both candidate distances in parallel; the side picks one
	always_comb begin
		lt   = lo1_s1 < lo2_s1;
		da   = (W+3)'(hi1_s1) - (W+3)'(lo2_s1);
		db   = (W+3)'(hi2_s1) - (W+3)'(lo1_s1);
		ov   = lt ? (!da[W+2] && (da != '0)) : (!db[W+2] && (db != '0));
		dsel = lt ? da[W-1:0] : db[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			flags_s2.overlap <= ov;
			flags_s2.neg     <= !lt;
			flags_s2.usable  <= vnz_s1 && (lt ? !vneg_s1 : vneg_s1);
			flags_s2.slow    <= mag_s1 < W'(rest_limit);
			dist2_s2         <= dsel;
			mag_s2           <= mag_s1;
		end
	end

	assign flags = flags_s2;
	assign dist2 = dist2_s2;
	assign mag   = mag_s2;

endmodule

[src/acr_choose.sv]
// Axis choice: entry-time cross products (stage 3), then the compare, normal
// and rounded penetration into the output register (stage 4). Depends on acr_pkg.
`timescale 1ns / 1ps

module acr_choose import acr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en_s3,
	input  logic                   en_s4,
	input  axis_flags_t            fx,
	input  axis_flags_t            fy,
	input  logic [COORD_BITS-1:0]  dx2,
	input  logic [COORD_BITS-1:0]  dy2,
	input  logic [COORD_BITS-1:0]  ax,
	input  logic [COORD_BITS-1:0]  ay,
	output logic                   hit,
	output logic signed [1:0]      normal_x,
	output logic signed [1:0]      normal_y,
	output logic [COORD_BITS-2:0]  penetration
);

	localparam int W = COORD_BITS;

	axis_flags_t      fx_s3, fy_s3;
	logic [W-1:0]     dx_s3, dy_s3;
	logic [2*W-1:0]   px_s3, py_s3;

	logic             hit_c, pick_x;
	logic [W:0]       rnd;
	logic signed [1:0] nx_c, ny_c;
	logic [W-2:0]     pen_c;

	logic             hit_s4;
	logic signed [1:0] nx_s4, ny_s4;
	logic [W-2:0]     pen_s4;

	// x entry is earlier when dx2/|vx| < dy2/|vy|, i.e. dx2*|vy| < dy2*|vx|
	always_ff @(posedge clk) begin
		if (en_s3) begin
			fx_s3 <= fx;
			fy_s3 <= fy;
			dx_s3 <= dx2;
			dy_s3 <= dy2;
			px_s3 <= (2*W)'(dx2) * (2*W)'(ay);
			py_s3 <= (2*W)'(dy2) * (2*W)'(ax);
		end
	end

	always_comb begin
		hit_c  = fx_s3.overlap && fy_s3.overlap;
		pick_x = fx_s3.usable && (!fy_s3.usable || (px_s3 < py_s3));
		rnd    = (W+1)'(pick_x ? dx_s3 : dy_s3) + (W+1)'(1);
		nx_c   = NORM_ZERO;
		ny_c   = NORM_ZERO;
		pen_c  = '0;
		if (hit_c && !(fx_s3.slow && fy_s3.slow)) begin
			pen_c = rnd[W-1:1];
			if (pick_x) begin
				nx_c = fx_s3.neg ? NORM_NEG : NORM_POS;
			end else begin
				ny_c = fy_s3.neg ? NORM_NEG : NORM_POS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hit_s4 <= hit_c;
			nx_s4  <= nx_c;
			ny_s4  <= ny_c;
			pen_s4 <= pen_c;
		end
	end

	assign hit         = hit_s4;
	assign normal_x    = nx_s4;
	assign normal_y    = ny_s4;
	assign penetration = pen_s4;

endmodule

[src/aabb_collision_response.sv]
// Rectangle collision response, four-stage pipeline: spans, overlap/distance,
// entry-time products, decision into the output register.
// Throughput one item per cycle, each stage holding only while the stage after it
// is full and stalled.
// Reset: all stage valid bits clear, rest_limit returns to 3.
`timescale 1ns / 1ps

module aabb_collision_response import acr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rest_limit_we,
	input  logic [7:0]                   rest_limit_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic        [COORD_BITS-2:0] first_width,
	input  logic        [COORD_BITS-2:0] first_height,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic        [COORD_BITS-2:0] second_width,
	input  logic        [COORD_BITS-2:0] second_height,
	input  logic signed [COORD_BITS-1:0] vel_x,
	input  logic signed [COORD_BITS-1:0] vel_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic signed [1:0]            normal_x,
	output logic signed [1:0]            normal_y,
	output logic        [COORD_BITS-2:0] penetration
);

	logic [7:0] rest_limit_q;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       rdy1, rdy2, rdy3, rdy4;

	axis_flags_t            fx, fy;
	logic [COORD_BITS-1:0]  dx2, dy2, ax, ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_limit_q <= REST_LIMIT_RESET;
		end else if (rest_limit_we) begin
			rest_limit_q <= rest_limit_wdata;
		end
	end

	// A stage loads when it is empty or its content moves on this cycle
	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s4;

	acr_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk        (clk),
		.en_s1      (rdy1),
		.en_s2      (rdy2),
		.rest_limit (rest_limit_q),
		.c1         (first_x),
		.s1         (first_width),
		.c2         (second_x),
		.s2         (second_width),
		.v          (vel_x),
		.flags      (fx),
		.dist2      (dx2),
		.mag        (ax)
	);

	acr_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk        (clk),
		.en_s1      (rdy1),
		.en_s2      (rdy2),
		.rest_limit (rest_limit_q),
		.c1         (first_y),
		.s1         (first_height),
		.c2         (second_y),
		.s2         (second_height),
		.v          (vel_y),
		.flags      (fy),
		.dist2      (dy2),
		.mag        (ay)
	);

	acr_choose #(.COORD_BITS(COORD_BITS)) u_choose (
		.clk         (clk),
		.en_s3       (rdy3),
		.en_s4       (rdy4),
		.fx          (fx),
		.fy          (fy),
		.dx2         (dx2),
		.dy2         (dy2),
		.ax          (ax),
		.ay          (ay),
		.hit         (hit),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.penetration (penetration)
	);

	// A miss carries no normal and no distance
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> normal_x == NORM_ZERO && normal_y == NORM_ZERO
			&& penetration == '0)
		else $error("miss result with nonzero normal or penetration");

	// Only one axis is ever chosen
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x == NORM_ZERO || normal_y == NORM_ZERO)
		else $error("both normals set");

	// An item in stage 3 that may advance shows up at the output next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy4 |=> out_valid)
		else $error("item lost between stage 3 and output");

endmodule

[tb/tb_top.sv]
// Self-checking bench for aabb_collision_response: directed and random rectangle pairs,
// predicted contact results checked in order against the DUT output stream.
// Depends on src/acr_pkg.sv and src/aabb_collision_response.sv.
`timescale 1ns / 1ps

import acr_pkg::*;

localparam int CB = COORD_BITS_DEF;

typedef struct packed {
	logic signed [CB-1:0] first_x;
	logic signed [CB-1:0] first_y;
	logic        [CB-2:0] first_width;
	logic        [CB-2:0] first_height;
	logic signed [CB-1:0] second_x;
	logic signed [CB-1:0] second_y;
	logic        [CB-2:0] second_width;
	logic        [CB-2:0] second_height;
	logic signed [CB-1:0] vel_x;
	logic signed [CB-1:0] vel_y;
} rect_pair_t;

typedef struct packed {
	logic                 hit;
	logic signed [1:0]    normal_x;
	logic signed [1:0]    normal_y;
	logic        [CB-2:0] penetration;
} contact_t;

class contact_scoreboard;
	contact_t    expected_q[$];
	logic [7:0]  rest_limit;
	int          mismatches;
	int          checked;

	function new();
		rest_limit = REST_LIMIT_RESET;
		mismatches = 0;
		checked = 0;
	endfunction

	// Spans are compared at double scale so half sizes stay exact
	function void span_overlap(input longint c1, input longint s1, input longint c2,
			input longint s2, output bit ov, output logic signed [1:0] nrm,
			output longint d2);
		longint lo1, hi1, lo2, hi2;
		lo1 = 2 * c1 - s1;
		hi1 = 2 * c1 + s1;
		lo2 = 2 * c2 - s2;
		hi2 = 2 * c2 + s2;
		ov = 0;
		nrm = NORM_ZERO;
		d2 = 0;
		if (lo1 < lo2) begin
			if (hi1 > lo2) begin
				ov = 1;
				nrm = NORM_POS;
				d2 = hi1 - lo2;
			end
		end else if (hi2 > lo1) begin
			ov = 1;
			nrm = NORM_NEG;
			d2 = hi2 - lo1;
		end
	endfunction

	function contact_t predict_contact(rect_pair_t p);
		contact_t r;
		bit ovx, ovy, okx, oky, pick_x;
		logic signed [1:0] nx, ny;
		longint dx2, dy2, vx, vy, ax, ay, pen;
		r = '0;
		span_overlap(longint'(p.first_x), longint'(p.first_width), longint'(p.second_x),
			longint'(p.second_width), ovx, nx, dx2);
		span_overlap(longint'(p.first_y), longint'(p.first_height), longint'(p.second_y),
			longint'(p.second_height), ovy, ny, dy2);
		if (!(ovx && ovy))
			return r;
		r.hit = 1'b1;
		vx = longint'(p.vel_x);
		vy = longint'(p.vel_y);
		ax = (vx < 0) ? -vx : vx;
		ay = (vy < 0) ? -vy : vy;
		if (ax < longint'(rest_limit) && ay < longint'(rest_limit))
			return r;
		// usable only when moving into the entry side
		okx = (nx == NORM_POS && vx > 0) || (nx == NORM_NEG && vx < 0);
		oky = (ny == NORM_POS && vy > 0) || (ny == NORM_NEG && vy < 0);
		if (!okx)
			pick_x = 0;
		else if (!oky)
			pick_x = 1;
		else
			pick_x = (dx2 * ay) < (dy2 * ax);
		if (pick_x) begin
			r.normal_x = nx;
			pen = (dx2 + 1) >> 1;
		end else begin
			r.normal_y = ny;
			pen = (dy2 + 1) >> 1;
		end
		r.penetration = pen[CB-2:0];
		return r;
	endfunction

	function void note_pair(rect_pair_t p);
		expected_q.push_back(predict_contact(p));
	endfunction

	task report_mismatch(string field, longint got_v, longint want_v);
		if (mismatches < 50)
			$display("mismatch on %s: got %0d, expected %0d (result %0d)",
				field, got_v, want_v, checked);
		mismatches++;
	endtask

	task check_contact(contact_t got);
		contact_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected result, hit", longint'(got.hit), longint'(0));
			return;
		end
		want = expected_q.pop_front();
		if (got.hit !== want.hit)
			report_mismatch("hit", longint'(got.hit), longint'(want.hit));
		if (got.normal_x !== want.normal_x)
			report_mismatch("normal_x", longint'(got.normal_x), longint'(want.normal_x));
		if (got.normal_y !== want.normal_y)
			report_mismatch("normal_y", longint'(got.normal_y), longint'(want.normal_y));
		if (got.penetration !== want.penetration)
			report_mismatch("penetration", longint'(got.penetration),
				longint'(want.penetration));
		checked++;
	endtask
endclass

module tb_top;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 222;
	localparam int HOLD_OFF_CYCLES = 120;

	logic                 clk;
	logic                 arst_n;
	logic                 rest_limit_we;
	logic [7:0]           rest_limit_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [CB-1:0] first_x, first_y, second_x, second_y, vel_x, vel_y;
	logic        [CB-2:0] first_width, first_height, second_width, second_height;
	logic                 out_valid;
	logic                 out_ready;
	logic                 hit;
	logic signed [1:0]    normal_x, normal_y;
	logic        [CB-2:0] penetration;

	contact_scoreboard sb;
	int quiet_cycles = 0;
	int burst_left = 0;
	bit hold_off_req = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_count = 0;

	aabb_collision_response #(.COORD_BITS(CB)) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.rest_limit_we    (rest_limit_we),
		.rest_limit_wdata (rest_limit_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_x          (first_x),
		.first_y          (first_y),
		.first_width      (first_width),
		.first_height     (first_height),
		.second_x         (second_x),
		.second_y         (second_y),
		.second_width     (second_width),
		.second_height    (second_height),
		.vel_x            (vel_x),
		.vel_y            (vel_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.normal_x         (normal_x),
		.normal_y         (normal_y),
		.penetration      (penetration)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic rect_pair_t make_pair(int x1, int y1, int w1, int h1, int x2, int y2,
			int w2, int h2, int vx, int vy);
		rect_pair_t p;
		p.first_x = CB'(x1);
		p.first_y = CB'(y1);
		p.first_width = (CB-1)'(w1);
		p.first_height = (CB-1)'(h1);
		p.second_x = CB'(x2);
		p.second_y = CB'(y2);
		p.second_width = (CB-1)'(w2);
		p.second_height = (CB-1)'(h2);
		p.vel_x = CB'(vx);
		p.vel_y = CB'(vy);
		return p;
	endfunction

	// Mostly small rectangles so that pairs land close together
	function automatic int pick_size();
		if ($urandom_range(0, 7) == 0)
			return int'($urandom_range(0, 23'h7fffff));
		return int'($urandom_range(0, 2047));
	endfunction

	function automatic int pick_velocity();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return int'($urandom_range(0, 600)) - 300;
			3: case ($urandom_range(0, 3))
				0: return -8388608;
				1: return 8388607;
				2: return -1;
				default: return 1;
			endcase
			8, 9: return int'($urandom);
			default: return int'($urandom_range(0, 131070)) - 65535;
		endcase
	endfunction

	function automatic int near_center(int c, int wa, int wb);
		int span;
		span = (wa + wb) / 2 + 1;
		return c + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Places a pair edge to edge on one axis, offset by -1, 0 or +1 LSB
	function automatic int edge_center(int c, int wa, int wb);
		int delta;
		delta = int'($urandom_range(0, 2)) - 1;
		if ($urandom_range(0, 1))
			return c - (wa + wb) / 2 + delta;
		return c + (wa + wb) / 2 - delta;
	endfunction

	function automatic rect_pair_t random_pair();
		rect_pair_t p;
		int roll, w1, h1, w2, h2, x2, y2, off, v;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			p.first_x = CB'($urandom);
			p.first_y = CB'($urandom);
			p.first_width = (CB-1)'($urandom);
			p.first_height = (CB-1)'($urandom);
			p.second_x = CB'($urandom);
			p.second_y = CB'($urandom);
			p.second_width = (CB-1)'($urandom);
			p.second_height = (CB-1)'($urandom);
			p.vel_x = CB'($urandom);
			p.vel_y = CB'($urandom);
			return p;
		end
		w1 = pick_size();
		h1 = pick_size();
		w2 = pick_size();
		h2 = pick_size();
		x2 = int'($urandom_range(0, 24'hffffff)) - 8388608;
		y2 = int'($urandom_range(0, 24'hffffff)) - 8388608;
		if (roll < 30) begin
			if ((w1 + w2) % 2)
				w1 = w1 ^ 1;
			if ((h1 + h2) % 2)
				h1 = h1 ^ 1;
			if ($urandom_range(0, 1))
				p = make_pair(edge_center(x2, w1, w2), near_center(y2, h1, h2), w1, h1,
					x2, y2, w2, h2, pick_velocity(), pick_velocity());
			else
				p = make_pair(near_center(x2, w1, w2), edge_center(y2, h1, h2), w1, h1,
					x2, y2, w2, h2, pick_velocity(), pick_velocity());
		end else if (roll < 40) begin
			// square-like pair with equal offsets and speeds: entry times tie
			off = int'($urandom_range(0, w1 + w2 + 2)) - (w1 + w2) / 2 - 1;
			v = pick_velocity();
			p = make_pair(x2 + off, y2 + off, w1, w1, x2, y2, w2, w2, v, v);
		end else begin
			p = make_pair(near_center(x2, w1, w2), near_center(y2, h1, h2), w1, h1,
				x2, y2, w2, h2, pick_velocity(), pick_velocity());
		end
		return p;
	endfunction

	task automatic offer_pair(rect_pair_t p);
		int gap;
		in_valid <= 1'b1;
		{first_x, first_y, first_width, first_height, second_x, second_y, second_width,
			second_height, vel_x, vel_y} <= p;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 30);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		// step past the current clock edge first so the last input transfer is already noted
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_rest_limit(logic [7:0] v);
		wait_drain();
		rest_limit_we <= 1'b1;
		rest_limit_wdata <= v;
		@(posedge clk);
		rest_limit_we <= 1'b0;
		sb.rest_limit = v;
	endtask

	// Receiver: stall pattern changes mode after a random run
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_mode_left = $urandom_range(32, 400);
				end
				rx_mode_left--;
				rx_count++;
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_count % 5) < 3;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pair({first_x, first_y, first_width, first_height, second_x, second_y,
					second_width, second_height, vel_x, vel_y});
			if (out_valid && out_ready)
				sb.check_contact({hit, normal_x, normal_y, penetration});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] lim;
		sb = new();
		arst_n = 1'b0;
		rest_limit_we = 1'b0;
		rest_limit_wdata = '0;
		in_valid = 1'b0;
		{first_x, first_y, first_width, first_height, second_x, second_y, second_width,
			second_height, vel_x, vel_y} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset rest_limit
		offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_pair(make_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607));
		offer_pair(make_pair(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
			8388607, 8388607, -8388608, -8388608));
		offer_pair(make_pair(0, 0, 256, 256, 1024, 0, 256, 256, 100, 0));
		offer_pair(make_pair(0, 0, 256, 256, 256, 0, 256, 256, 5, 0));      // edges touch
		offer_pair(make_pair(0, 0, 1, 256, 1, 0, 2, 256, 5, 0));            // half-LSB overlap
		offer_pair(make_pair(0, 0, 512, 512, 100, 50, 512, 512, 0, 0));     // at rest
		offer_pair(make_pair(0, 0, 512, 512, 100, 50, 512, 512, 2, -2));
		offer_pair(make_pair(0, 0, 512, 512, 100, 50, 512, 512, 3, 0));
		offer_pair(make_pair(0, 0, 512, 512, 100, 100, 512, 512, 256, 128));
		offer_pair(make_pair(0, 0, 512, 512, 100, 100, 512, 512, 128, 256));
		offer_pair(make_pair(0, 0, 512, 512, 100, 100, 512, 512, 256, 256)); // tie
		offer_pair(make_pair(0, 0, 512, 512, 100, 100, 512, 512, -256, -256));
		offer_pair(make_pair(100, 100, 512, 512, 0, 0, 512, 512, -300, -200));
		offer_pair(make_pair(0, 0, 0, 0, 0, 0, 512, 512, 10, 10));        // zero-size first
		offer_pair(make_pair(0, 0, 512, 512, 0, 0, 0, 0, -10, -20));      // zero-size second
		offer_pair(make_pair(0, 0, 512, 512, 40, 40, 512, 512, -3, 2));
		offer_pair(make_pair(100, 0, 512, 512, 0, 0, 512, 512, -8388608, 1));
		offer_pair(make_pair(0, 0, 8388607, 8388607, 5, -7, 3, 3, 1, -8388608));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 8'd0;
				1: lim = 8'd255;
				2: lim = 8'd1;
				5: lim = 8'd128;
				default: lim = 8'($urandom_range(0, 255));
			endcase
			set_rest_limit(lim);
			// receiver holds off while the sender keeps offering
			if (ph == 1 || ph == 4)
				hold_off_req = 1;
			repeat (PHASE_ITEMS) offer_pair(random_pair());
		end

		wait_drain();
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
